/* hw/rtl/dsdpcp_pkg.sv */
`default_nettype none

package dsdpcp_pkg;

    // Four-character tags, big-endian as they appear in the stream
    localparam logic [31:0] TAG_SND  = 32'h534E_4420;
    localparam logic [31:0] TAG_FS   = 32'h4653_2020;
    localparam logic [31:0] TAG_CHNL = 32'h4348_4E4C;
    localparam logic [31:0] TAG_CMPR = 32'h434D_5052;
    localparam logic [31:0] TAG_DST  = 32'h4453_5420;

    localparam logic [31:0] RATE_64  = 32'd2822400;
    localparam logic [31:0] RATE_128 = 32'd5644800;
    localparam logic [31:0] RATE_256 = 32'd11289600;

    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned PREFIX_BYTES = 4;

    // rate * bits = 1000 * KBPS_Qxx + remainder; remainder is 600 or 400,
    // i.e. 3/5 or 2/5 of a kilobit per channel.
    localparam logic [21:0] KBPS_Q64  = 22'd180633;
    localparam logic [21:0] KBPS_Q128 = 22'd722534;
    localparam logic [21:0] KBPS_Q256 = 22'd2890137;

    // floor(x / 5) = (x * DIV5_MUL) >> DIV5_SHIFT for x < 2**18
    localparam logic [15:0] DIV5_MUL   = 16'd52429;
    localparam int unsigned DIV5_SHIFT = 18;

    typedef struct packed {
        logic        type_ok;
        logic        dst;
        logic [31:0] rate;
        logic [15:0] chans;
    } dsdpcp_snap_t;

endpackage

`default_nettype wire

/* hw/rtl/dsd_property_chunk_parser.sv */
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_data_byte[7:0], s_last_byte
// m_        out        m_valid / m_ready  m_type_ok, m_sample_rate[31:0],
//                                         m_channel_count[15:0], m_dst_encoded,
//                                         m_bits_per_sample[8:0], m_bitrate_kbps[37:0]
//
// One byte taken per cycle while s_ready is high; the parser state updates in the
// cycle a byte is accepted. A last-byte request's result passes through the summary
// stage, then the bitrate multipliers into the output register.
// s_ready drops only when both the summary stage and the output register are full
// and m_ready is low. aresetn (synchronous) returns the parser to the start of a body.

module dsd_property_chunk_parser (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_data_byte,
    input  wire         s_last_byte,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_type_ok,
    output logic [31:0] m_sample_rate,
    output logic [15:0] m_channel_count,
    output logic        m_dst_encoded,
    output logic [8:0]  m_bits_per_sample,
    output logic [37:0] m_bitrate_kbps
);
    import dsdpcp_pkg::*;

    // parser state
    logic [2:0]  prefix_count_reg, prefix_count_next;
    logic        type_match_reg, type_match_next;
    logic [32:0] chunk_offset_reg, chunk_offset_next;
    logic [31:0] chunk_id_reg, chunk_id_next;
    logic [31:0] chunk_length_reg, chunk_length_next;
    logic [31:0] field_value_reg, field_value_next;
    logic [31:0] rate_store_reg, rate_store_next;
    logic [15:0] channel_store_reg, channel_store_next;
    logic        compressed_reg, compressed_next;

    // summary stage and output register
    logic         snap_valid_reg, snap_valid_next;
    dsdpcp_snap_t snap_reg, snap_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_ok_reg, out_dst_reg;
    logic [31:0]  out_rate_reg;
    logic [15:0]  out_chans_reg;
    logic [8:0]   out_bits_reg;
    logic [37:0]  out_kbps_reg;

    logic        accept;
    logic        advance;
    logic [7:0]  snd_byte;
    logic [33:0] pos_inc;
    logic        in_body_field;

    // bitrate datapath
    logic [8:0]  bits_sel;
    logic [21:0] kbps_q;
    logic [17:0] frac_num;
    logic [37:0] kbps_whole;
    logic [33:0] frac_prod;
    logic [37:0] kbps_total;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !snap_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign snd_byte      = 8'(TAG_SND >> {~prefix_count_reg[1:0], 3'b000});
    assign pos_inc       = {1'b0, chunk_offset_reg} + 34'd1;
    assign in_body_field = (chunk_offset_reg >= 33'(HEADER_BYTES))
                        && (chunk_offset_reg <  33'(HEADER_BYTES + 4));

    // Byte walk: tag prefix, then sub-chunk header (id, 8-byte size) and body.
    always_comb begin
        prefix_count_next  = prefix_count_reg;
        type_match_next    = type_match_reg;
        chunk_offset_next  = chunk_offset_reg;
        chunk_id_next      = chunk_id_reg;
        chunk_length_next  = chunk_length_reg;
        field_value_next   = field_value_reg;
        rate_store_next    = rate_store_reg;
        channel_store_next = channel_store_reg;
        compressed_next    = compressed_reg;

        if (prefix_count_reg < 3'(PREFIX_BYTES)) begin
            if (snd_byte != s_data_byte) begin
                type_match_next = 1'b0;
            end
            prefix_count_next = prefix_count_reg + 3'd1;
        end else begin
            if (chunk_offset_reg < 33'd4) begin
                chunk_id_next = (chunk_offset_reg == 33'd0) ? {24'd0, s_data_byte}
                                                            : {chunk_id_reg[23:0], s_data_byte};
            end else if (chunk_offset_reg >= 33'd8
                         && chunk_offset_reg < 33'(HEADER_BYTES)) begin
                // only the low word of the 64-bit size survives the shift
                chunk_length_next = (chunk_offset_reg == 33'd8)
                                  ? {24'd0, s_data_byte}
                                  : {chunk_length_reg[23:0], s_data_byte};
            end else if (in_body_field) begin
                // HEADER_BYTES is a multiple of four, so the low bits give the body index
                field_value_next = (chunk_offset_reg[1:0] == 2'd0)
                                 ? {24'd0, s_data_byte}
                                 : {field_value_reg[23:0], s_data_byte};
                if (chunk_id_reg == TAG_FS && chunk_offset_reg[1:0] == 2'd3) begin
                    rate_store_next = field_value_next;
                end else if (chunk_id_reg == TAG_CHNL && chunk_offset_reg[1:0] == 2'd1) begin
                    channel_store_next = field_value_next[15:0];
                end else if (chunk_id_reg == TAG_CMPR && chunk_offset_reg[1:0] == 2'd3) begin
                    compressed_next = (field_value_next == TAG_DST);
                end
            end

            // end of sub-chunk uses the size as updated by this byte
            if (pos_inc >= 34'(HEADER_BYTES) + {2'b00, chunk_length_next}) begin
                chunk_offset_next = 33'd0;
            end else begin
                chunk_offset_next = pos_inc[32:0];
            end
        end
    end

    // Summary of the finished body, taken from the post-update state
    always_comb begin
        snap_next.type_ok = (prefix_count_next == 3'(PREFIX_BYTES)) && type_match_next;
        snap_next.dst     = snap_next.type_ok && compressed_next;
        snap_next.rate    = (snap_next.type_ok && !compressed_next) ? rate_store_next : 32'd0;
        snap_next.chans   = (snap_next.type_ok && !compressed_next) ? channel_store_next
                                                                    : 16'd0;
    end

    always_comb begin
        snap_valid_next = snap_valid_reg;
        if (advance) begin
            snap_valid_next = 1'b0;
        end
        if (accept && s_last_byte) begin
            snap_valid_next = 1'b1;
        end
        out_valid_next = advance ? snap_valid_reg : out_valid_reg;
    end

    // Bits per sample and the exact kbps: q*ch + floor(r*ch/1000), r/1000 = 3/5 or 2/5
    always_comb begin
        bits_sel = 9'd0;
        kbps_q   = 22'd0;
        frac_num = 18'd0;
        if (snap_reg.rate == RATE_64) begin
            bits_sel = 9'd64;
            kbps_q   = KBPS_Q64;
            frac_num = {2'b00, snap_reg.chans} + {1'b0, snap_reg.chans, 1'b0};
        end else if (snap_reg.rate == RATE_128) begin
            bits_sel = 9'd128;
            kbps_q   = KBPS_Q128;
            frac_num = {1'b0, snap_reg.chans, 1'b0};
        end else if (snap_reg.rate == RATE_256) begin
            bits_sel = 9'd256;
            kbps_q   = KBPS_Q256;
            frac_num = {2'b00, snap_reg.chans} + {1'b0, snap_reg.chans, 1'b0};
        end
        kbps_whole = 38'(kbps_q) * 38'(snap_reg.chans);
        frac_prod  = 34'(frac_num) * 34'(DIV5_MUL);
        kbps_total = kbps_whole + 38'(frac_prod >> DIV5_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_count_reg  <= 3'd0;
            type_match_reg    <= 1'b1;
            chunk_offset_reg  <= 33'd0;
            chunk_id_reg      <= 32'd0;
            chunk_length_reg  <= 32'd0;
            field_value_reg   <= 32'd0;
            rate_store_reg    <= 32'd0;
            channel_store_reg <= 16'd0;
            compressed_reg    <= 1'b0;
            snap_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
            if (accept) begin
                if (s_last_byte) begin
                    // body done: back to the start-of-body state
                    prefix_count_reg  <= 3'd0;
                    type_match_reg    <= 1'b1;
                    chunk_offset_reg  <= 33'd0;
                    chunk_id_reg      <= 32'd0;
                    chunk_length_reg  <= 32'd0;
                    field_value_reg   <= 32'd0;
                    rate_store_reg    <= 32'd0;
                    channel_store_reg <= 16'd0;
                    compressed_reg    <= 1'b0;
                end else begin
                    prefix_count_reg  <= prefix_count_next;
                    type_match_reg    <= type_match_next;
                    chunk_offset_reg  <= chunk_offset_next;
                    chunk_id_reg      <= chunk_id_next;
                    chunk_length_reg  <= chunk_length_next;
                    field_value_reg   <= field_value_next;
                    rate_store_reg    <= rate_store_next;
                    channel_store_reg <= channel_store_next;
                    compressed_reg    <= compressed_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            snap_reg <= snap_next;
        end
        if (advance && snap_valid_reg) begin
            out_ok_reg    <= snap_reg.type_ok;
            out_dst_reg   <= snap_reg.dst;
            out_rate_reg  <= snap_reg.rate;
            out_chans_reg <= snap_reg.chans;
            out_bits_reg  <= bits_sel;
            out_kbps_reg  <= kbps_total;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_type_ok         = out_ok_reg;
    assign m_sample_rate     = out_rate_reg;
    assign m_channel_count   = out_chans_reg;
    assign m_dst_encoded     = out_dst_reg;
    assign m_bits_per_sample = out_bits_reg;
    assign m_bitrate_kbps    = out_kbps_reg;

endmodule

`default_nettype wire

/* tb/sv/property_summary_checker.sv */
`timescale 1ns / 1ps

module property_summary_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire  [7:0]  s_data_byte,
    input  wire         s_last_byte,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire         m_type_ok,
    input  wire  [31:0] m_sample_rate,
    input  wire  [15:0] m_channel_count,
    input  wire         m_dst_encoded,
    input  wire  [8:0]  m_bits_per_sample,
    input  wire  [37:0] m_bitrate_kbps,
    output int unsigned fault_total,
    output int unsigned results_outstanding
);

    import dsdpcp_pkg::*;

    typedef struct packed {
        logic        type_ok;
        logic [31:0] rate;
        logic [15:0] chans;
        logic        dst;
        logic [8:0]  bits;
        logic [37:0] kbps;
    } chunk_summary_t;

    chunk_summary_t expected_summaries[$];
    int unsigned    fault_tally;

    // parser state as predicted
    logic [2:0]  tag_bytes_seen;
    logic        tag_matches;
    logic [32:0] sub_pos;
    logic [31:0] sub_id;
    logic [31:0] sub_len;
    logic [31:0] field_acc;
    logic [31:0] rate_seen;
    logic [15:0] chans_seen;
    logic        dst_seen;

    task automatic clear_parse_state;
        tag_bytes_seen = '0;
        tag_matches    = 1'b1;
        sub_pos        = '0;
        sub_id         = '0;
        sub_len        = '0;
        field_acc      = '0;
        rate_seen      = '0;
        chans_seen     = '0;
        dst_seen       = 1'b0;
    endtask

    task automatic parse_body_byte(input logic [7:0] b, input logic is_last);
        logic [31:0]    tag_slice;
        logic [32:0]    body_pos;
        chunk_summary_t s;
        longint unsigned product;
        if (tag_bytes_seen < 3'(PREFIX_BYTES)) begin
            tag_slice = TAG_SND >> (8 * (3 - int'(tag_bytes_seen)));
            if (tag_slice[7:0] != b) tag_matches = 1'b0;
            tag_bytes_seen = tag_bytes_seen + 3'd1;
        end else begin
            if (sub_pos < 33'd4) begin
                sub_id = (sub_pos == 33'd0) ? {24'd0, b} : {sub_id[23:0], b};
            end else if (sub_pos >= 33'd8 && sub_pos < 33'(HEADER_BYTES)) begin
                sub_len = (sub_pos == 33'd8) ? {24'd0, b} : {sub_len[23:0], b};
            end else if (sub_pos >= 33'(HEADER_BYTES)) begin
                body_pos = sub_pos - 33'(HEADER_BYTES);
                if (body_pos < 33'd4) begin
                    field_acc = (body_pos == 33'd0) ? {24'd0, b} : {field_acc[23:0], b};
                    if (sub_id == TAG_FS && body_pos == 33'd3)
                        rate_seen = field_acc;
                    else if (sub_id == TAG_CHNL && body_pos == 33'd1)
                        chans_seen = field_acc[15:0];
                    else if (sub_id == TAG_CMPR && body_pos == 33'd3)
                        dst_seen = (field_acc == TAG_DST);
                end
            end
            // offset never wraps: an oversized sub-chunk eats the rest of the body
            if (34'(sub_pos) + 34'd1 >= 34'(HEADER_BYTES) + 34'(sub_len))
                sub_pos = '0;
            else
                sub_pos = sub_pos + 33'd1;
        end

        if (is_last) begin
            s = '0;
            s.type_ok = (tag_bytes_seen == 3'(PREFIX_BYTES)) && tag_matches;
            if (s.type_ok) begin
                s.dst = dst_seen;
                if (!dst_seen) begin
                    s.rate  = rate_seen;
                    s.chans = chans_seen;
                end
            end
            case (s.rate)
                RATE_64:  s.bits = 9'd64;
                RATE_128: s.bits = 9'd128;
                RATE_256: s.bits = 9'd256;
                default:  s.bits = 9'd0;
            endcase
            product = 64'(s.rate) * 64'(s.bits) * 64'(s.chans);
            s.kbps  = 38'(product / 64'd1000);
            expected_summaries.push_back(s);
            clear_parse_state();
        end
    endtask

    task automatic check_field(input string label, input logic [63:0] expected,
                               input logic [63:0] actual);
        if (expected !== actual) begin
            fault_tally++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, label, expected, actual);
        end
    endtask

    always @(posedge aclk) begin
        chunk_summary_t want;
        if (!aresetn) begin
            clear_parse_state();
            expected_summaries.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_summaries.size() == 0) begin
                    fault_tally++;
                    $display("%0t: unexpected result, expected none, got rate 0x%0h chans 0x%0h",
                             $time, m_sample_rate, m_channel_count);
                end else begin
                    want = expected_summaries.pop_front();
                    check_field("type_ok", 64'(want.type_ok), 64'(m_type_ok));
                    check_field("sample_rate", 64'(want.rate), 64'(m_sample_rate));
                    check_field("channel_count", 64'(want.chans), 64'(m_channel_count));
                    check_field("dst_encoded", 64'(want.dst), 64'(m_dst_encoded));
                    check_field("bits_per_sample", 64'(want.bits), 64'(m_bits_per_sample));
                    check_field("bitrate_kbps", 64'(want.kbps), 64'(m_bitrate_kbps));
                end
            end
            if (s_valid && s_ready)
                parse_body_byte(s_data_byte, s_last_byte);
        end
        fault_total         <= fault_tally;
        results_outstanding <= expected_summaries.size();
    end

endmodule

/* tb/sv/dsd_property_chunk_parser_test.sv */
`timescale 1ns / 1ps

module dsd_property_chunk_parser_test;

    import dsdpcp_pkg::*;

    // generous: ~1400 bytes with full sender gaps and receiver stalls come
    // nowhere near this
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_last_byte = 1'b0;
    logic        m_ready     = 1'b1;
    wire         s_ready;
    wire         m_valid;
    wire         m_type_ok;
    wire  [31:0] m_sample_rate;
    wire  [15:0] m_channel_count;
    wire         m_dst_encoded;
    wire  [8:0]  m_bits_per_sample;
    wire  [37:0] m_bitrate_kbps;

    int unsigned fault_total;
    int unsigned results_outstanding;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent  = 0;
    int unsigned bodies_sent = 0;

    // idle_on gates all random idling; it is switched off for the tail of the run
    bit idle_on    = 1'b1;
    // a quiet body is sent with no sender gaps at all
    bit quiet_body = 1'b0;

    // bytes of the body being built, sent front to back
    logic [7:0] body_bytes[$];

    dsd_property_chunk_parser DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_type_ok         (m_type_ok),
        .m_sample_rate     (m_sample_rate),
        .m_channel_count   (m_channel_count),
        .m_dst_encoded     (m_dst_encoded),
        .m_bits_per_sample (m_bits_per_sample),
        .m_bitrate_kbps    (m_bitrate_kbps)
    );

    property_summary_checker checker_inst (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .s_last_byte         (s_last_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_type_ok           (m_type_ok),
        .m_sample_rate       (m_sample_rate),
        .m_channel_count     (m_channel_count),
        .m_dst_encoded       (m_dst_encoded),
        .m_bits_per_sample   (m_bits_per_sample),
        .m_bitrate_kbps      (m_bitrate_kbps),
        .fault_total         (fault_total),
        .results_outstanding (results_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // watchdog: a hung handshake or a lost result ends up here
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stall bursts between ready stretches.
    // Stalls only bite when results pile up, so back-to-back tiny bodies are
    // sent now and then to fill both output stages.
    initial begin
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // Append the low 'count' bytes of value, most significant first.
    task automatic put_be(input logic [63:0] value, input int count);
        for (int i = count - 1; i >= 0; i--)
            body_bytes.push_back(value[8 * i +: 8]);
    endtask

    // One request per byte. Called at a rising edge; returns at the edge the
    // byte is taken, with valid still high so that the next byte can follow
    // without a bubble.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        if (idle_on && !quiet_body && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= value;
        s_last_byte <= is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Send the first 'count' bytes of the built body, marking the last one,
    // then discard the buffer. A count short of the full size cuts the body
    // mid-header or mid-field.
    task automatic send_body(input int count);
        for (int i = 0; i < count; i++)
            send_byte(body_bytes[i], i == count - 1);
        body_bytes.delete();
        bodies_sent++;
    endtask

    // Hold off the sender until every predicted summary has been seen. The
    // first edge lets the checker's count catch up with the last request.
    task automatic wait_for_results;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        int          n_sub;
        int          flen;
        int          cut;
        int          pick;
        int          cap;
        bit          huge;
        bit          drained_mid;
        logic [31:0] sub_id_w;
        logic [31:0] field_w;
        logic [63:0] size_w;

        drained_mid = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed ----
        // lone 0xFF: body ends inside the type tag
        put_be(64'hFF, 1);
        send_body(1);
        // "SN" then a zero byte: short and wrong
        put_be(64'h53_4E_00, 3);
        send_body(3);
        // bare "SND ": tag good, nothing captured
        put_be(64'(TAG_SND), 4);
        send_body(4);
        // one case bit off in the tag
        put_be(64'(TAG_SND ^ 32'h0000_2000), 4);
        send_body(4);
        // top rate with the most channels: largest bitrate
        put_be(64'(TAG_SND), 4);
        put_be(64'(TAG_FS), 4);
        put_be(64'd4, 8);
        put_be(64'(RATE_256), 4);
        put_be(64'(TAG_CHNL), 4);
        put_be(64'd2, 8);
        put_be(64'hFFFF, 2);
        send_body(body_bytes.size());
        // compressed stream: rate and channels must come back cleared
        put_be(64'(TAG_SND), 4);
        put_be(64'(TAG_FS), 4);
        put_be(64'd4, 8);
        put_be(64'(RATE_64), 4);
        put_be(64'(TAG_CMPR), 4);
        put_be(64'd4, 8);
        put_be(64'(TAG_DST), 4);
        send_body(body_bytes.size());
        wait_for_results();

        // ---- random bodies ----
        while (bytes_sent < 1300 || bodies_sent < 60) begin
            if (bytes_sent >= 1100) idle_on = 1'b0;
            quiet_body = ($urandom_range(0, 3) == 0);
            if (!drained_mid && bodies_sent >= 30) begin
                drained_mid = 1'b1;
                wait_for_results();
            end

            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                // run of one-byte bodies: results back to back, pushes on s_ready
                repeat ($urandom_range(2, 6)) begin
                    put_be(64'($urandom), 1);
                    send_body(1);
                end
            end else begin
                if (pick == 1) begin
                    // tag cut short: correct prefix, then the body ends
                    flen = $urandom_range(1, 3);
                    put_be(64'(TAG_SND >> (8 * (4 - flen))), flen);
                end else if (pick == 2) begin
                    put_be(64'(TAG_SND ^ (32'd1 << $urandom_range(0, 31))), 4);
                end else begin
                    put_be(64'(TAG_SND), 4);
                end

                n_sub = (pick == 1) ? 0 : $urandom_range(0, 4);
                huge  = 1'b0;
                for (int k = 0; k < n_sub && !huge; k++) begin
                    flen = 4;
                    case ($urandom_range(0, 9))
                        0, 1, 2: begin
                            sub_id_w = TAG_FS;
                            case ($urandom_range(0, 7))
                                0:       field_w = RATE_64;
                                1:       field_w = RATE_128;
                                2:       field_w = RATE_256;
                                3:       field_w = RATE_128 + 32'($urandom_range(0, 2)) - 32'd1;
                                4:       field_w = 32'hFFFF_FFFF;
                                5:       field_w = 32'd0;
                                default: field_w = $urandom;
                            endcase
                        end
                        3, 4: begin
                            sub_id_w = TAG_CHNL;
                            flen     = 2;
                            case ($urandom_range(0, 5))
                                0:       field_w = 32'd1;
                                1:       field_w = 32'd2;
                                2:       field_w = 32'd6;
                                3:       field_w = 32'hFFFF;
                                4:       field_w = 32'd0;
                                default: field_w = $urandom_range(0, 65535);
                            endcase
                        end
                        5, 6: begin
                            sub_id_w = TAG_CMPR;
                            case ($urandom_range(0, 5))
                                0, 1, 2: field_w = TAG_DST;
                                3:       field_w = 32'h4453_4420;   // "DSD ", uncompressed
                                4:       field_w = TAG_DST ^ (32'd1 << $urandom_range(0, 31));
                                default: field_w = $urandom;
                            endcase
                        end
                        7: begin
                            // some other sub-chunk, skipped
                            sub_id_w = $urandom;
                            field_w  = $urandom;
                            flen     = $urandom_range(0, 4);
                        end
                        8: begin
                            // one bit away from a known identifier
                            sub_id_w = ($urandom_range(0, 1) ? TAG_FS : TAG_CHNL)
                                       ^ (32'd1 << $urandom_range(0, 31));
                            field_w  = RATE_64;
                        end
                        default: begin
                            // oversized: swallows the rest of the body
                            huge     = 1'b1;
                            sub_id_w = $urandom_range(0, 1) ? TAG_FS : $urandom;
                            field_w  = RATE_256;
                        end
                    endcase

                    if (huge) begin
                        size_w = {($urandom_range(0, 1) ? $urandom : 32'd0),
                                  32'hFFFF_FFFF - 32'($urandom_range(0, 15))};
                    end else begin
                        case ($urandom_range(0, 9))
                            6:       size_w = 64'($urandom_range(0, flen));
                            7, 8:    size_w = 64'(flen + $urandom_range(1, 6));
                            9:       size_w = {$urandom | 32'd1, 32'(flen)}; // high half ignored
                            default: size_w = 64'(flen);
                        endcase
                    end
                    put_be(64'(sub_id_w), 4);
                    put_be(size_w, 8);

                    cap = huge ? $urandom_range(0, 24) : int'(size_w[31:0]);
                    for (int j = 0; j < cap; j++) begin
                        if (j < flen)
                            body_bytes.push_back(field_w[8 * (flen - 1 - j) +: 8]);
                        else
                            body_bytes.push_back(8'($urandom));
                    end
                end

                cut = body_bytes.size();
                if ($urandom_range(0, 5) == 0) cut = $urandom_range(1, cut);
                send_body(cut);
            end
        end

        wait_for_results();
        repeat (16) @(posedge aclk);
        if (fault_total == 0 && results_outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
